@@ rtl/slv_pkg.sv @@
// Shared types, constants and helpers for the four-joint servo slew limiter.
// No dependencies; every other file of the block depends on this package.
package slv_pkg;

  localparam int ANGLE_W    = 12;
  localparam int DEG_W      = 8;
  localparam int STEP_W     = 8;
  localparam int EV_W       = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int JOINTS_DEF = 4;
  // Arm joints that have a target field of their own (base, shoulder, elbow)
  localparam int ARM_FIELDS = 3;

  typedef logic [ANGLE_W-1:0]    angle_t;
  typedef logic [DEG_W-1:0]      deg_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [EV_W-1:0]       ev_t;
  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam angle_t POS_MAX   = angle_t'(2880);
  localparam angle_t POS_RESET = angle_t'(1440);

  localparam step_t  ARM_STEP_RST  = step_t'(8);
  localparam step_t  GRIP_STEP_RST = step_t'(64);
  localparam angle_t TOL_RST       = angle_t'(32);

  // Event codes carried in the mode field of a command beat
  localparam ev_t EV_TICK     = 2'd0;
  localparam ev_t EV_SET_ALL  = 2'd1;
  localparam ev_t EV_SET_GRIP = 2'd2;

  // Motion mode codes reported in the arm_mode field of a result beat
  localparam mode_t MODE_IDLE   = 2'd0;
  localparam mode_t MODE_MOVING = 2'd1;
  localparam mode_t MODE_ERROR  = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t CFG_ARM_STEP  = 2'd0;
  localparam cfg_idx_t CFG_GRIP_STEP = 2'd1;
  localparam cfg_idx_t CFG_TOLERANCE = 2'd2;

  // Per-beat control decoded at the input, shared by lanes and merge
  typedef struct packed {
    logic tick;
    logic set_all;
    logic set_grip;
    logic write_failed;
  } slv_ctl_t;

  function automatic angle_t sat_pos(input angle_t v);
    return (v > POS_MAX) ? POS_MAX : v;
  endfunction

  function automatic deg_t to_deg(input angle_t a);
    return a[ANGLE_W-1:ANGLE_W-DEG_W];
  endfunction

endpackage

@@ rtl/slv_if.sv @@
// Valid/ready channel interfaces for command and result beats.
// Depends on slv_pkg for field types.
interface slv_cmd_if;
  logic             valid;
  logic             ready;
  slv_pkg::ev_t     mode;
  slv_pkg::angle_t  target_base;
  slv_pkg::angle_t  target_shoulder;
  slv_pkg::angle_t  target_elbow;
  slv_pkg::angle_t  target_grip;
  logic             write_failed;

  modport source (output valid, mode, target_base, target_shoulder, target_elbow,
                  target_grip, write_failed, input ready);
  modport sink   (input valid, mode, target_base, target_shoulder, target_elbow,
                  target_grip, write_failed, output ready);
endinterface

interface slv_res_if;
  logic             valid;
  logic             ready;
  logic             servo_valid;
  slv_pkg::deg_t    base_deg;
  slv_pkg::deg_t    shoulder_deg;
  slv_pkg::deg_t    elbow_deg;
  slv_pkg::deg_t    gripper_deg;
  slv_pkg::mode_t   arm_mode;
  logic             at_target;

  modport source (output valid, servo_valid, base_deg, shoulder_deg, elbow_deg,
                  gripper_deg, arm_mode, at_target, input ready);
  modport sink   (input valid, servo_valid, base_deg, shoulder_deg, elbow_deg,
                  gripper_deg, arm_mode, at_target, output ready);
endinterface

@@ rtl/slv_lane.sv @@
// One joint lane: current and target angle, slew step and tolerance check.
// Depends on slv_pkg.
module slv_lane (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  slv_pkg::angle_t load_val,
  input  logic            tick,
  input  slv_pkg::step_t  step,
  input  slv_pkg::angle_t tolerance,
  output slv_pkg::angle_t cur,
  output logic            moved,
  output logic            near
);
  import slv_pkg::*;

  angle_t tgt;
  angle_t diff;
  angle_t step_x;
  angle_t cur_next;

  // Distance to target, shared by the slew step and the at-target check
  assign diff   = (cur > tgt) ? cur - tgt : tgt - cur;
  assign step_x = angle_t'(step);
  assign moved  = diff > step_x;
  assign near   = diff < tolerance;

  // Step toward target, or snap when within one step
  always_comb begin
    if (moved) begin
      cur_next = (tgt > cur) ? cur + step_x : cur - step_x;
    end else begin
      cur_next = tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= POS_RESET;
      tgt <= POS_RESET;
    end else begin
      if (tick) begin
        cur <= cur_next;
      end
      if (load) begin
        tgt <= sat_pos(load_val);
      end
    end
  end

endmodule

@@ rtl/slv_merge.sv @@
// Merge stage: combines lane flags into the motion mode and at-target bit.
// Depends on slv_pkg.
module slv_merge #(
  parameter int JOINTS = slv_pkg::JOINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  slv_pkg::slv_ctl_t ctl,
  input  logic [JOINTS-1:0] moved,
  input  logic [JOINTS-1:0] near,
  output slv_pkg::mode_t    mode,
  output logic              moving,
  output logic              at_target
);
  import slv_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    ST_IDLE   = MODE_IDLE,
    ST_MOVING = MODE_MOVING,
    ST_FAULT  = MODE_ERROR
  } state_t;

  state_t state;

  assign mode      = mode_t'(state);
  assign moving    = (state == ST_MOVING);
  assign at_target = &near;

  // Motion mode: set events start motion, ticks settle or fault
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (ctl.set_all || ctl.set_grip) begin
      state <= ST_MOVING;
    end else if (ctl.tick) begin
      if (ctl.write_failed) begin
        state <= ST_FAULT;
      end else if (moved == '0) begin
        state <= ST_IDLE;
      end
    end
  end

endmodule

@@ rtl/four_joint_servo_slew_limiter.sv @@
// Four-joint servo slew limiter. One command beat is accepted per clock while
// ready is high: the joint lanes and the mode register update at the accepting
// edge, and the result, read from the new state, is held in the forming stage
// and loaded into the output register once that register is empty or its beat
// is taken; the sustained rate is one beat per cycle while the output is not
// stalled. Input ready drops only when both the forming stage and the output
// register hold a beat and the output is stalled.
// Configuration writes (arm_step, gripper_step, tolerance) take effect at the
// write edge and are meant to be issued while no beat is in flight.
module four_joint_servo_slew_limiter #(
  parameter int JOINTS = slv_pkg::JOINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  slv_cmd_if.sink               cmd,
  slv_res_if.source             res,
  input  logic                  cfg_we,
  input  slv_pkg::cfg_idx_t     cfg_index,
  input  slv_pkg::cfg_data_t    cfg_wdata
);
  import slv_pkg::*;

  step_t    arm_step;
  step_t    gripper_step;
  angle_t   tolerance;

  slv_ctl_t          ctl;
  logic              fire;
  logic              moving;
  mode_t             mode;
  logic              at_target;
  logic [JOINTS-1:0] moved;
  logic [JOINTS-1:0] near;
  angle_t            cur [JOINTS];

  logic   pend_v;
  logic   pend_servo;
  logic   pend_move;
  deg_t   base_d;
  deg_t   shoulder_d;
  deg_t   elbow_d;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      arm_step     <= ARM_STEP_RST;
      gripper_step <= GRIP_STEP_RST;
      tolerance    <= TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ARM_STEP:  arm_step     <= cfg_wdata[STEP_W-1:0];
        CFG_GRIP_STEP: gripper_step <= cfg_wdata[STEP_W-1:0];
        CFG_TOLERANCE: tolerance    <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake and event decode
  assign pend_move    = pend_v && (!res.valid || res.ready);
  assign cmd.ready    = !pend_v || !res.valid || res.ready;
  assign fire         = cmd.valid && cmd.ready;
  assign ctl.tick     = fire && (cmd.mode == EV_TICK) && moving;
  assign ctl.set_all  = fire && (cmd.mode == EV_SET_ALL);
  assign ctl.set_grip = fire && (cmd.mode == EV_SET_GRIP);
  assign ctl.write_failed = cmd.write_failed;

  // Joint lanes; the last lane is the gripper
  for (genvar i = 0; i < JOINTS; i++) begin : g_lane
    angle_t raw;
    logic   ld;
    step_t  stp;

    if (i == JOINTS - 1) begin : g_grip
      assign raw = cmd.target_grip;
      assign ld  = ctl.set_all || ctl.set_grip;
      assign stp = gripper_step;
    end else begin : g_arm
      if (i == 0) begin : g_base
        assign raw = cmd.target_base;
      end else if (i == 1) begin : g_shoulder
        assign raw = cmd.target_shoulder;
      end else if (i == 2) begin : g_elbow
        assign raw = cmd.target_elbow;
      end else begin : g_nofield
        assign raw = POS_RESET;
      end
      assign ld  = ctl.set_all && (i < ARM_FIELDS);
      assign stp = arm_step;
    end

    slv_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .load      (ld),
      .load_val  (raw),
      .tick      (ctl.tick),
      .step      (stp),
      .tolerance (tolerance),
      .cur       (cur[i]),
      .moved     (moved[i]),
      .near      (near[i])
    );
  end

  slv_merge #(.JOINTS(JOINTS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .moved     (moved),
    .near      (near),
    .mode      (mode),
    .moving    (moving),
    .at_target (at_target)
  );

  // Arm joint angles; joints that do not exist report zero
  if (JOINTS > 1) begin : g_o0
    assign base_d = to_deg(cur[0]);
  end else begin : g_z0
    assign base_d = '0;
  end
  if (JOINTS > 2) begin : g_o1
    assign shoulder_d = to_deg(cur[1]);
  end else begin : g_z1
    assign shoulder_d = '0;
  end
  if (JOINTS > 3) begin : g_o2
    assign elbow_d = to_deg(cur[2]);
  end else begin : g_z2
    assign elbow_d = '0;
  end

  // Forming stage: remembers a beat whose result is read from the new state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (fire) begin
      pend_v <= 1'b1;
    end else if (pend_move) begin
      pend_v <= 1'b0;
    end
    if (fire) begin
      pend_servo <= ctl.tick;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pend_move) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (pend_move) begin
      res.servo_valid  <= pend_servo;
      res.base_deg     <= base_d;
      res.shoulder_deg <= shoulder_d;
      res.elbow_deg    <= elbow_d;
      res.gripper_deg  <= to_deg(cur[JOINTS-1]);
      res.arm_mode     <= mode;
      res.at_target    <= at_target;
    end
  end

  // Checks
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (pend_v && res.valid && !res.ready))
    else $error("ready low without a full, stalled pipeline");

  a_fire_pend: assert property (@(posedge clk) disable iff (rst)
    fire |=> pend_v)
    else $error("accepted beat not held in forming stage");

  a_pend_fwd: assert property (@(posedge clk) disable iff (rst)
    (pend_v && !res.valid) |=> res.valid)
    else $error("formed result did not reach the output register");

  a_tick_moving: assert property (@(posedge clk) disable iff (rst)
    ctl.tick |-> (mode == MODE_MOVING))
    else $error("slew tick taken outside moving mode");

endmodule
